// File: hw/rtl/bols_pkg.sv
// Shared types and constants for the bounded ordered list store.
package bols_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned ACTION_W = 3;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned ERROR_W  = 2;

    typedef enum logic [ACTION_W-1:0] {
        A_INS_FRONT = 3'd0,
        A_INS_BACK  = 3'd1,
        A_INS_AT    = 3'd2,
        A_CONTAINS  = 3'd3,
        A_REMOVE    = 3'd4,
        A_POP_FRONT = 3'd5,
        A_POP_BACK  = 3'd6
    } t_action;

    typedef enum logic [ERROR_W-1:0] {
        E_OK    = 2'd0,
        E_FULL  = 2'd1,
        E_EMPTY = 2'd2
    } t_error;

    // What a cell loads on an update cycle
    typedef enum logic [2:0] {
        SEL_KEEP,
        SEL_LEFT,
        SEL_RIGHT,
        SEL_LOAD,
        SEL_CLEAR
    } t_sel;

    typedef struct packed {
        t_sel sel;
        logic capture;  // latch match / marker flags
        logic scan;     // advance the flag and tap chain by one cell
        logic search;   // compare own entry against the item value
    } t_cell_ctl;

endpackage

// File: hw/rtl/bounded_ordered_list_store.sv
// Top level of the bounded ordered list store: command sequencer over a row of cells.
//
//  channel   direction  handshake                       payload
//  command   in         start && !busy                   i_action, i_position, i_item_value
//  result    out        o_result_valid (one cycle)       o_popped_value, o_found,
//                                                        o_entry_count, o_error_code
//
// Insert front/back/at, pop front and the unused code: item accepted, state goes
// straight to apply, result registered from apply, busy meanwhile and no new item taken.
// Contains, remove and pop back: item accepted, then the match, scan and apply states,
// busy meanwhile; the scan lasts until the match flag / tap chain, moving one cell per
// cycle, reaches the tail of the row.
// Synchronous active-low reset empties the list; the result strobe cannot be stalled.
module bounded_ordered_list_store #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [bols_pkg::ACTION_W-1:0]      i_action,
    input  logic [bols_pkg::POS_W-1:0]         i_position,
    input  logic signed [bols_pkg::VALUE_W-1:0] i_item_value,
    output logic                               o_result_valid,
    output logic signed [bols_pkg::VALUE_W-1:0] o_popped_value,
    output logic                               o_found,
    output logic [bols_pkg::COUNT_W-1:0]       o_entry_count,
    output logic [bols_pkg::ERROR_W-1:0]       o_error_code
);
    import bols_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned AW = (CW > POS_W) ? CW : POS_W;
    localparam int unsigned EW = AW + 1;
    localparam int unsigned SW = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_SCAN,
        S_APPLY
    } t_state;

    t_state             r_state;
    logic               r_busy;
    t_action            r_act;
    logic [POS_W-1:0]   r_pos;
    logic [VALUE_W-1:0] r_val;
    logic [CW-1:0]      r_used;
    logic [SW-1:0]      r_cnt;
    logic               r_res_valid;
    logic [VALUE_W-1:0] r_popped;
    logic               r_found;
    logic [COUNT_W-1:0] r_count;
    t_error             r_err;

    logic [VALUE_W-1:0] cell_data [CAPACITY];
    logic               cell_seen [CAPACITY];
    logic [VALUE_W-1:0] cell_tap  [CAPACITY];
    t_cell_ctl          cell_ctl  [CAPACITY];

    logic               accept;
    logic               is_apply;
    logic [EW-1:0]      used_e;
    logic [EW-1:0]      pos_e;
    logic [EW-1:0]      ins_at_len;
    logic               full;
    logic               ins_at_err;
    logic               empty;
    logic [CW-1:0]      n_used;
    logic [VALUE_W-1:0] n_popped;
    logic               n_found;
    t_error             n_err;

    assign accept   = start && !r_busy;
    assign is_apply = (r_state == S_APPLY);
    assign used_e   = EW'(r_used);
    assign pos_e    = EW'(r_pos);
    assign ins_at_len = (pos_e > used_e) ? (pos_e + EW'(1)) : (used_e + EW'(1));
    assign full       = (r_used >= CW'(CAPACITY));
    assign ins_at_err = (ins_at_len > EW'(CAPACITY));
    assign empty      = (r_used == '0);

    // Row of cells with per-slot update select
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [VALUE_W-1:0] left_data;
        logic [VALUE_W-1:0] right_data;
        logic               left_seen;
        logic [VALUE_W-1:0] left_tap;
        logic               slot_valid;
        logic               slot_mark;
        t_sel               sel;

        if (k == 0) begin : g_head
            assign left_data = '0;
            assign left_seen = 1'b0;
            assign left_tap  = '0;
        end else begin : g_body
            assign left_data = cell_data[k-1];
            assign left_seen = cell_seen[k-1];
            assign left_tap  = cell_tap[k-1];
        end

        if (k == CAPACITY - 1) begin : g_tail
            assign right_data = '0;
        end else begin : g_mid
            assign right_data = cell_data[k+1];
        end

        assign slot_valid = (EW'(k) < used_e);
        assign slot_mark  = (r_act == A_POP_BACK) && (EW'(k + 1) == used_e);

        always_comb begin
            sel = SEL_KEEP;
            if (is_apply) begin
                case (r_act)
                    A_INS_FRONT: begin
                        if (!full) sel = (k == 0) ? SEL_LOAD : SEL_LEFT;
                    end
                    A_INS_BACK: begin
                        if (!full && slot_mark == 1'b0 && EW'(k) == used_e) sel = SEL_LOAD;
                    end
                    A_INS_AT: begin
                        // gap slots past the old end already hold zero
                        if (!ins_at_err) begin
                            if (EW'(k) == pos_e)     sel = SEL_LOAD;
                            else if (EW'(k) > pos_e) sel = SEL_LEFT;
                        end
                    end
                    A_REMOVE: begin
                        if (cell_seen[k]) sel = SEL_RIGHT;
                    end
                    A_POP_FRONT: begin
                        if (!empty) sel = SEL_RIGHT;
                    end
                    A_POP_BACK: begin
                        if (!empty && cell_seen[k]) sel = SEL_CLEAR;
                    end
                    default: sel = SEL_KEEP;
                endcase
            end
        end

        assign cell_ctl[k].sel     = sel;
        assign cell_ctl[k].capture = (r_state == S_MATCH);
        assign cell_ctl[k].scan    = (r_state == S_SCAN);
        assign cell_ctl[k].search  = (r_act == A_CONTAINS) || (r_act == A_REMOVE);

        bols_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl[k]),
            .i_value      (r_val),
            .i_valid      (slot_valid),
            .i_mark       (slot_mark),
            .i_left_data  (left_data),
            .i_right_data (right_data),
            .i_left_seen  (left_seen),
            .i_left_tap   (left_tap),
            .o_data       (cell_data[k]),
            .o_seen       (cell_seen[k]),
            .o_tap        (cell_tap[k])
        );
    end

    // Result and new count for the update cycle
    always_comb begin
        n_used   = r_used;
        n_popped = '0;
        n_found  = 1'b0;
        n_err    = E_OK;
        case (r_act)
            A_INS_FRONT, A_INS_BACK: begin
                if (full) n_err = E_FULL;
                else      n_used = r_used + CW'(1);
            end
            A_INS_AT: begin
                if (ins_at_err) n_err = E_FULL;
                else            n_used = CW'(ins_at_len);
            end
            A_CONTAINS: begin
                n_found = cell_seen[CAPACITY-1];
            end
            A_REMOVE: begin
                n_found = cell_seen[CAPACITY-1];
                if (cell_seen[CAPACITY-1]) n_used = r_used - CW'(1);
            end
            A_POP_FRONT: begin
                if (empty) begin
                    n_err = E_EMPTY;
                end else begin
                    n_popped = cell_data[0];
                    n_used   = r_used - CW'(1);
                end
            end
            A_POP_BACK: begin
                if (empty) begin
                    n_err = E_EMPTY;
                end else begin
                    n_popped = cell_tap[CAPACITY-1];
                    n_used   = r_used - CW'(1);
                end
            end
            default: n_used = r_used;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= 1'b0;
            r_used      <= '0;
            r_cnt       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_busy <= 1'b1;
                        r_act  <= t_action'(i_action);
                        r_pos  <= i_position;
                        r_val  <= i_item_value;
                        if (t_action'(i_action) == A_CONTAINS ||
                            t_action'(i_action) == A_REMOVE ||
                            t_action'(i_action) == A_POP_BACK) begin
                            r_state <= S_MATCH;
                        end else begin
                            r_state <= S_APPLY;
                        end
                    end
                end
                S_MATCH: begin
                    r_cnt   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_cnt == SW'(CAPACITY - 2)) begin
                        r_state <= S_APPLY;
                    end else begin
                        r_cnt <= r_cnt + SW'(1);
                    end
                end
                S_APPLY: begin
                    r_used      <= n_used;
                    r_res_valid <= 1'b1;
                    r_popped    <= n_popped;
                    r_found     <= n_found;
                    r_count     <= COUNT_W'(n_used);
                    r_err       <= n_err;
                    r_busy      <= 1'b0;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign busy           = r_busy;
    assign o_result_valid = r_res_valid;
    assign o_popped_value = r_popped;
    assign o_found        = r_found;
    assign o_entry_count  = r_count;
    assign o_error_code   = r_err;

endmodule

// File: hw/rtl/bols_cell.sv
// One list slot: entry register, neighbor shift, match flag and tap chain stage.
module bols_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bols_pkg::t_cell_ctl       i_ctl,
    input  logic [bols_pkg::VALUE_W-1:0] i_value,
    input  logic                      i_valid,
    input  logic                      i_mark,
    input  logic [bols_pkg::VALUE_W-1:0] i_left_data,
    input  logic [bols_pkg::VALUE_W-1:0] i_right_data,
    input  logic                      i_left_seen,
    input  logic [bols_pkg::VALUE_W-1:0] i_left_tap,
    output logic [bols_pkg::VALUE_W-1:0] o_data,
    output logic                      o_seen,
    output logic [bols_pkg::VALUE_W-1:0] o_tap
);
    import bols_pkg::*;

    logic [VALUE_W-1:0] r_data, n_data;
    logic               r_seen, n_seen;
    logic [VALUE_W-1:0] r_tap, n_tap;

    always_comb begin
        case (i_ctl.sel)
            SEL_KEEP:  n_data = r_data;
            SEL_LEFT:  n_data = i_left_data;
            SEL_RIGHT: n_data = i_right_data;
            SEL_LOAD:  n_data = i_value;
            SEL_CLEAR: n_data = '0;
            default:   n_data = r_data;
        endcase
    end

    always_comb begin
        n_seen = r_seen;
        n_tap  = r_tap;
        if (i_ctl.capture) begin
            n_seen = (i_ctl.search && i_valid && (r_data == i_value)) || i_mark;
            n_tap  = i_mark ? r_data : '0;
        end else if (i_ctl.scan) begin
            // flags and tapped value ripple toward the tail one cell per cycle
            n_seen = r_seen | i_left_seen;
            n_tap  = r_tap | i_left_tap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
            r_seen <= 1'b0;
            r_tap  <= '0;
        end else begin
            r_data <= n_data;
            r_seen <= n_seen;
            r_tap  <= n_tap;
        end
    end

    assign o_data = r_data;
    assign o_seen = r_seen;
    assign o_tap  = r_tap;

endmodule

// File: hw/rtl/bols_checker.sv
// Port-level checks for the bounded ordered list store, bound to the top level.
module bols_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_result_valid,
    input logic [31:0] o_popped_value,
    input logic        o_found,
    input logic [4:0]  o_entry_count,
    input logic [1:0]  o_error_code
);
    import bols_pkg::*;

    // an accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // a result only closes out an item that was in progress
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result without an item in progress");

    a_error_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_error_code == E_OK || o_error_code == E_FULL ||
                            o_error_code == E_EMPTY))
        else $error("undefined error code");

    // refused pops leave an empty list and return zero
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_error_code == E_EMPTY) |->
            (o_entry_count == 5'd0 && o_popped_value == 32'd0 && !o_found))
        else $error("empty pop reported wrong fields");

    a_found_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_found) |-> (o_error_code == E_OK))
        else $error("found flagged together with an error");

endmodule

bind bounded_ordered_list_store bols_checker u_bols_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_popped_value (o_popped_value),
    .o_found        (o_found),
    .o_entry_count  (o_entry_count),
    .o_error_code   (o_error_code)
);
